@@ sv/fsmc_pkg.sv @@
// ----------------------------------------------------------------------------
// fsmc_pkg: shared types and constants of the binary64 sign/min/max/compare unit
// Operation codes, the canonical NaN constant and the stage-to-stage payload structs.
// ----------------------------------------------------------------------------
package fsmc_pkg;

    typedef enum logic [3:0] {
        OP_SGNJ  = 4'd0,
        OP_SGNJN = 4'd1,
        OP_SGNJX = 4'd2,
        OP_MIN   = 4'd3,
        OP_MAX   = 4'd4,
        OP_EQ    = 4'd5,
        OP_LT    = 4'd6,
        OP_LE    = 4'd7,
        OP_CLASS = 4'd8
    } t_op;

    localparam logic [63:0] CANON_NAN = 64'h7FF8_0000_0000_0000;

    // Operand facts found in the decode stage.
    typedef struct packed {
        logic a_nan;
        logic b_nan;
        logic a_snan;
        logic b_snan;
        logic both_zero;
        logic equal;
        logic [9:0] a_class;
    } t_flags;

    // Payload carried from decode to the compare stage.
    typedef struct packed {
        logic [3:0]  op;
        logic [63:0] a_bits;
        logic [63:0] b_bits;
        logic [63:0] key_a;
        logic [63:0] key_b;
        t_flags      flags;
    } t_dec;

endpackage

@@ sv/fsmc_decode.sv @@
// ----------------------------------------------------------------------------
// fsmc_decode: operand decode stage
// Finds NaN and zero of the operands and class of the first, and builds the order keys.
// ----------------------------------------------------------------------------
module fsmc_decode import fsmc_pkg::*; (
    input  logic [3:0]  i_op,
    input  logic [63:0] i_a_bits,
    input  logic [63:0] i_b_bits,
    output t_dec        o_dec
);

    logic a_exp_max, b_exp_max, a_frac_nz, b_frac_nz, a_exp_zero, neg;
    logic [9:0] a_class;

    assign a_exp_max  = &i_a_bits[62:52];
    assign b_exp_max  = &i_b_bits[62:52];
    assign a_frac_nz  = |i_a_bits[51:0];
    assign b_frac_nz  = |i_b_bits[51:0];
    assign a_exp_zero = ~|i_a_bits[62:52];
    assign neg        = i_a_bits[63];

    // Classify the first operand into a one-hot mask
    always_comb begin
        if (a_exp_max) begin
            if (a_frac_nz) a_class = i_a_bits[51] ? 10'h200 : 10'h100;
            else a_class = neg ? 10'h001 : 10'h080;
        end else if (a_exp_zero) begin
            if (!a_frac_nz) a_class = neg ? 10'h008 : 10'h010;
            else a_class = neg ? 10'h004 : 10'h020;
        end else begin
            a_class = neg ? 10'h002 : 10'h040;
        end
    end

    assign o_dec.flags.a_class   = a_class;
    assign o_dec.op              = i_op;
    assign o_dec.a_bits          = i_a_bits;
    assign o_dec.b_bits          = i_b_bits;
    assign o_dec.key_a           = i_a_bits[63] ? ~i_a_bits : {1'b1, i_a_bits[62:0]};
    assign o_dec.key_b           = i_b_bits[63] ? ~i_b_bits : {1'b1, i_b_bits[62:0]};
    assign o_dec.flags.a_nan     = a_exp_max & a_frac_nz;
    assign o_dec.flags.b_nan     = b_exp_max & b_frac_nz;
    assign o_dec.flags.a_snan    = a_exp_max & a_frac_nz & ~i_a_bits[51];
    assign o_dec.flags.b_snan    = b_exp_max & b_frac_nz & ~i_b_bits[51];
    assign o_dec.flags.both_zero = ~|i_a_bits[62:0] & ~|i_b_bits[62:0];
    assign o_dec.flags.equal     = (i_a_bits == i_b_bits);

endmodule

@@ sv/fsmc_select.sv @@
// ----------------------------------------------------------------------------
// fsmc_select: result selection stage
// Picks the result and invalid flag from the decoded operands and the compare.
// ----------------------------------------------------------------------------
module fsmc_select import fsmc_pkg::*; (
    input  t_dec        i_dec,
    input  logic        i_lt,
    input  logic        i_gt,
    output logic [63:0] o_result_bits,
    output logic        o_invalid_flag
);

    logic any_nan, any_snan, lt, gt, eq;

    assign any_nan  = i_dec.flags.a_nan | i_dec.flags.b_nan;
    assign any_snan = i_dec.flags.a_snan | i_dec.flags.b_snan;
    assign lt = i_lt & ~i_dec.flags.both_zero;
    assign gt = i_gt & ~i_dec.flags.both_zero;
    assign eq = i_dec.flags.equal | i_dec.flags.both_zero;

    always_comb begin
        o_result_bits  = '0;
        o_invalid_flag = 1'b0;
        case (i_dec.op)
            OP_SGNJ:  o_result_bits = {i_dec.b_bits[63], i_dec.a_bits[62:0]};
            OP_SGNJN: o_result_bits = {~i_dec.b_bits[63], i_dec.a_bits[62:0]};
            OP_SGNJX: o_result_bits = {i_dec.a_bits[63] ^ i_dec.b_bits[63],
                                       i_dec.a_bits[62:0]};
            OP_MIN, OP_MAX: begin
                o_invalid_flag = any_snan;
                if (i_dec.flags.a_nan && i_dec.flags.b_nan) o_result_bits = CANON_NAN;
                else if (i_dec.flags.a_nan) o_result_bits = i_dec.b_bits;
                else if (i_dec.flags.b_nan) o_result_bits = i_dec.a_bits;
                else if (i_dec.flags.both_zero)
                    o_result_bits = (i_dec.op == OP_MAX) ? (i_dec.a_bits & i_dec.b_bits)
                                                         : (i_dec.a_bits | i_dec.b_bits);
                else if (i_dec.op == OP_MAX) o_result_bits = lt ? i_dec.b_bits : i_dec.a_bits;
                else o_result_bits = gt ? i_dec.b_bits : i_dec.a_bits;
            end
            OP_EQ: begin
                o_invalid_flag   = any_snan;
                o_result_bits[0] = ~any_nan & eq;
            end
            OP_LT: begin
                o_invalid_flag   = any_nan;
                o_result_bits[0] = ~any_nan & lt;
            end
            OP_LE: begin
                o_invalid_flag   = any_nan;
                o_result_bits[0] = ~any_nan & (lt | eq);
            end
            OP_CLASS: o_result_bits = {54'd0, i_dec.flags.a_class};
            default: ;
        endcase
    end

endmodule

@@ sv/fp64_sign_minmax_compare_classify.sv @@
// ----------------------------------------------------------------------------
// fp64_sign_minmax_compare_classify: binary64 sign/min/max/compare/classify unit
// Three-stage pipeline: decode, 64-bit key compare, result select.
// ----------------------------------------------------------------------------
// Three register stages; an item passes r_dec1, r_dec2 and r_res before
// o_valid rises, and the output transfer follows when i_stall is low.
// Throughput: one item per cycle while i_stall is low; a stage takes a new item when it advances.
// A stall holds each full stage with no empty stage after it; an empty stage still fills.
// Reset (synchronous, active low) clears the stage valid bits only.
module fp64_sign_minmax_compare_classify import fsmc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [3:0]  i_op,
    input  logic [63:0] i_a_bits,
    input  logic [63:0] i_b_bits,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [63:0] o_result_bits,
    output logic        o_invalid_flag
);

    t_dec        n_dec, r_dec1, r_dec2;
    logic        r_v1, r_v2, r_v3, r_lt, r_gt;
    logic [63:0] n_res, r_res;
    logic        n_inv, r_inv;
    logic        adv3, adv2, adv1;

    // Advance a stage when it is empty or the next one moves
    assign adv3 = !r_v3 || !i_stall;
    assign adv2 = !r_v2 || adv3;
    assign adv1 = !r_v1 || adv2;
    assign o_stall = !adv1;

    fsmc_decode u_decode (
        .i_op(i_op), .i_a_bits(i_a_bits), .i_b_bits(i_b_bits), .o_dec(n_dec)
    );

    fsmc_select u_select (
        .i_dec(r_dec2), .i_lt(r_lt), .i_gt(r_gt),
        .o_result_bits(n_res), .o_invalid_flag(n_inv)
    );

    // Hold or advance the valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (adv1) r_v1 <= i_valid;
            if (adv2) r_v2 <= r_v1;
            if (adv3) r_v3 <= r_v2;
        end
    end

    // Payload registers; stage two does the wide key compare
    always_ff @(posedge i_clk) begin
        if (adv1) r_dec1 <= n_dec;
        if (adv2) begin
            r_dec2 <= r_dec1;
            r_lt   <= r_dec1.key_a < r_dec1.key_b;
            r_gt   <= r_dec1.key_a > r_dec1.key_b;
        end
        if (adv3) begin
            r_res <= n_res;
            r_inv <= n_inv;
        end
    end

    assign o_valid        = r_v3;
    assign o_result_bits  = r_res;
    assign o_invalid_flag = r_inv;

    // A stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_result_bits))
        else $error("stalled result changed");
    // An accepted item reaches the output when nothing stalls
    a_lat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) ##1 !i_stall ##1 !i_stall |=> o_valid)
        else $error("item lost in pipeline");
    // Compare results never both set
    a_cmp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v2 |-> !(r_lt && r_gt))
        else $error("lt and gt both set");

endmodule
